FILE: design/esum_pkg.sv
// shared types, codes and constants of the encoder speed uniformity monitor
package esum_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPD_MUL, ST_SPD_GO, ST_SPD_WAIT, ST_SCAN, ST_DEV_MUL, ST_DEV_SUB,
    ST_DEV_SCL, ST_DEV_GO, ST_DEV_WAIT, ST_MEAN_GO, ST_MEAN_WAIT, ST_WRITE, ST_LOAD
  } state_t;

  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [1:0] REG_WINDOW    = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_REFERENCE = 2'd2;

  localparam logic [1:0] VERDICT_FEW     = 2'd0;
  localparam logic [1:0] VERDICT_SLOW    = 2'd1;
  localparam logic [1:0] VERDICT_UNIFORM = 2'd2;
  localparam logic [1:0] VERDICT_UNEVEN  = 2'd3;

  localparam int COUNT_W = 11;
  localparam int WIN_W   = 9;

  localparam logic [8:0]  WINDOW_RESET    = 9'd40;
  localparam logic [12:0] THRESHOLD_RESET = 13'd200;
  localparam logic [8:0]  WIN_MIN         = 9'd5;
  localparam logic [8:0]  WIN_MAX         = 9'd300;
  localparam logic [31:0] MIN_DT          = 32'd500;
  localparam logic [24:0] SPEED_K         = 25'd29296875;
  localparam logic [13:0] DEV_SCALE       = 14'd10000;
  localparam logic [30:0] REF_MIN         = 31'd100;
  localparam logic [6:0]  MEAN_MIN        = 7'd100;
  localparam logic [63:0] SPEED_LIM       = 64'd1000000000;
  localparam logic [63:0] DEV_LIM         = 64'd1000000;
  localparam logic [3:0]  FEW_SAMPLES     = 4'd5;

  localparam int DIV_MW = 62;
  localparam int DIV_DW = 40;
  localparam int DIV_QW = 64;

  typedef struct packed {
    logic              start;
    logic [DIV_MW-1:0] mag;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

endpackage

FILE: design/esum_if.sv
// item channels of the monitor: encoder samples in, results out
interface esum_sample_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [31:0]        time_us;
  logic signed [31:0] position_counts;
  logic               is_continuous;
  modport source (output valid, cmd, time_us, position_counts, is_continuous, input ready);
  modport sink (input valid, cmd, time_us, position_counts, is_continuous, output ready);
endinterface

interface esum_result_if;
  logic                        valid;
  logic                        ready;
  logic signed [30:0]          speed_mrpm;
  logic signed [30:0]          mean_mrpm;
  logic signed [20:0]          sample_deviation;
  logic [19:0]                 peak_deviation;
  logic [1:0]                  verdict;
  logic [esum_pkg::COUNT_W-1:0] stored_samples;
  modport source (output valid, speed_mrpm, mean_mrpm, sample_deviation, peak_deviation,
                  verdict, stored_samples, input ready);
  modport sink (input valid, speed_mrpm, mean_mrpm, sample_deviation, peak_deviation,
                verdict, stored_samples, output ready);
endinterface

FILE: design/esum_ram.sv
// generic single-port-write ram with registered read
module esum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/esum_div.sv
// shared restoring divider giving round-half-away quotient of mag / den
module esum_div (
  input  logic               clk,
  input  logic               rst,
  input  esum_pkg::div_req_t req,
  output esum_pkg::div_rsp_t rsp
);
  localparam int QW = esum_pkg::DIV_QW;
  localparam int DW = esum_pkg::DIV_DW;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0] num;
  logic [QW-1:0] quo;
  logic [DW:0]   den2;
  logic [DW:0]   rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW+1:0] rem_sh;
  logic          fits;

  assign rem_sh = {rem, num[QW-1]};
  assign fits   = rem_sh >= {1'b0, den2};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        // numerator 2*mag + den, divisor 2*den
        num  <= {1'b0, req.mag, 1'b0} + QW'(req.den);
        den2 <= {req.den, 1'b0};
        rem  <= '0;
        cnt  <= CW'(QW);
        busy <= 1'b1;
      end else if (busy) begin
        num <= {num[QW-2:0], 1'b0};
        quo <= {quo[QW-2:0], fits};
        rem <= fits ? rem_sh[DW:0] - den2 : rem_sh[DW:0];
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
endmodule

FILE: design/encoder_speed_uniformity_monitor_top.sv
// top level of the encoder speed uniformity monitor
// One item is taken at a time. A clear command and the first sample after a clear go straight
// to the output; a sample closer than 500 us to the last one is dropped with no result. A regular
// sample makes up to three passes through the shared bit-serial divider (speed; deviation, only
// with a fixed reference or a large enough mean; mean) and one pass, one entry a cycle, over the
// older entries of the window (at most 300 entries) in the speed and deviation rings. The next item
// is taken while a result waits in the output register. The rings need no clearing pass; only
// entries written since the last clear are read.
module encoder_speed_uniformity_monitor_top #(
  parameter int RING_DEPTH    = 512,
  parameter int HISTORY_LIMIT = 1400
) (
  input  logic                 clk,
  input  logic                 rst,
  esum_sample_if.sink          sample,
  esum_result_if.source        result,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [30:0]          cfg_data
);
  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(HISTORY_LIMIT + 1);

  esum_pkg::state_t state, state_next;

  // configuration
  logic [8:0]         win;
  logic [12:0]        thr;
  logic signed [30:0] refv;

  // history
  logic               has_prev;
  logic               prev_cont;
  logic [31:0]        prev_time;
  logic signed [31:0] prev_pos;
  logic [AW-1:0]      wr_slot;
  logic [CW-1:0]      count;

  // working registers
  logic               zero_res;
  logic signed [33:0] delta_r;
  logic [31:0]        dt_r;
  logic               spd_neg;
  logic [58:0]        spd_prod;
  logic signed [30:0] speed_r;
  logic [8:0]         n_r;
  logic [8:0]         k;
  logic [AW-1:0]      ptr;
  logic               pend;
  logic signed [39:0] sum_r;
  logic [19:0]        peak_old;
  logic               fixed_r;
  logic               mean_ok_r;
  logic signed [41:0] p1;
  logic               diff_neg;
  logic [42:0]        diff_mag;
  logic [56:0]        num_mag;
  logic signed [20:0] dev_r;
  logic [19:0]        dev_abs;
  logic signed [30:0] mean_r;

  // ram and divider
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic signed [30:0] rd_speed;
  logic signed [20:0] rd_dev;
  esum_pkg::div_req_t div_req;
  esum_pkg::div_rsp_t div_rsp;

  // combinational helpers
  logic               take;
  logic [31:0]        dt;
  logic signed [33:0] delta_raw;
  logic signed [33:0] delta;
  logic [8:0]         w;
  logic [8:0]         n;
  logic [30:0]        ref_abs;
  logic [39:0]        sum_abs;
  logic               fixed_c;
  logic               mean_ok_c;
  logic signed [41:0] prod_n;
  logic signed [42:0] diff;
  logic [19:0]        rd_dev_abs;
  logic [AW-1:0]      slot_prev;
  logic [AW-1:0]      ptr_dec;
  logic               out_free;
  logic [63:0]        q_spd;
  logic [63:0]        q_dev;
  logic [63:0]        q_mean;
  logic [19:0]        peak_fin;

  esum_ram #(.WIDTH(31), .DEPTH(RING_DEPTH)) u_speed_ram (
    .clk(clk), .we(ram_we), .waddr(wr_slot), .wdata(speed_r),
    .raddr(ram_raddr), .rdata(rd_speed)
  );

  esum_ram #(.WIDTH(21), .DEPTH(RING_DEPTH)) u_dev_ram (
    .clk(clk), .we(ram_we), .waddr(wr_slot), .wdata(dev_r),
    .raddr(ram_raddr), .rdata(rd_dev)
  );

  esum_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign sample.ready = (state == esum_pkg::ST_IDLE);
  assign take         = sample.valid && sample.ready;
  assign out_free     = !result.valid || result.ready;

  assign dt        = sample.time_us - prev_time;
  assign delta_raw = 34'(sample.position_counts) - 34'(prev_pos);

  always_comb begin
    delta = delta_raw;
    // fold into half a turn when either side wraps per turn
    if (!(sample.is_continuous && prev_cont)) begin
      if (delta_raw > 34'sd32768) begin
        delta = delta_raw - 34'sd65536;
      end else if (delta_raw < -34'sd32768) begin
        delta = delta_raw + 34'sd65536;
      end
    end
  end

  always_comb begin
    w = win;
    if (win < esum_pkg::WIN_MIN) begin
      w = esum_pkg::WIN_MIN;
    end else if (win > esum_pkg::WIN_MAX) begin
      w = esum_pkg::WIN_MAX;
    end
    if (32'(w) > 32'(RING_DEPTH)) begin
      w = 9'(RING_DEPTH);
    end
  end

  assign n          = (32'(count) < 32'(w)) ? 9'(count) : w;
  assign ref_abs    = refv[30] ? 31'(-refv) : 31'(refv);
  assign sum_abs    = sum_r[39] ? 40'(-sum_r) : 40'(sum_r);
  assign fixed_c    = ref_abs >= esum_pkg::REF_MIN;
  assign mean_ok_c  = (n_r != '0) && (sum_abs >= 40'(n_r) * 40'(esum_pkg::MEAN_MIN));
  assign prod_n     = speed_r * $signed({1'b0, n_r});
  assign diff       = fixed_r ? 43'(p1) : 43'(p1) - 43'(sum_r);
  assign rd_dev_abs = rd_dev[20] ? 20'(-rd_dev) : rd_dev[19:0];
  assign slot_prev  = (wr_slot == '0) ? AW'(RING_DEPTH - 1) : wr_slot - 1'b1;
  assign ptr_dec    = (ptr == '0) ? AW'(RING_DEPTH - 1) : ptr - 1'b1;
  assign q_spd      = (div_rsp.quo > esum_pkg::SPEED_LIM) ? esum_pkg::SPEED_LIM : div_rsp.quo;
  assign q_dev      = (div_rsp.quo > esum_pkg::DEV_LIM) ? esum_pkg::DEV_LIM : div_rsp.quo;
  assign q_mean     = q_spd;
  assign peak_fin   = (fixed_r || mean_ok_r) ? ((dev_abs > peak_old) ? dev_abs : peak_old) : '0;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      esum_pkg::ST_IDLE: begin
        if (take) begin
          if (sample.cmd == esum_pkg::CMD_CLEAR || !has_prev) begin
            state_next = esum_pkg::ST_LOAD;
          end else if (dt >= esum_pkg::MIN_DT) begin
            state_next = esum_pkg::ST_SPD_MUL;
          end
        end
      end
      esum_pkg::ST_SPD_MUL:  state_next = esum_pkg::ST_SPD_GO;
      esum_pkg::ST_SPD_GO:   state_next = esum_pkg::ST_SPD_WAIT;
      esum_pkg::ST_SPD_WAIT: if (div_rsp.done) state_next = esum_pkg::ST_SCAN;
      esum_pkg::ST_SCAN:     if (k >= n_r && !pend) state_next = esum_pkg::ST_DEV_MUL;
      esum_pkg::ST_DEV_MUL:  state_next = esum_pkg::ST_DEV_SUB;
      esum_pkg::ST_DEV_SUB:  state_next = esum_pkg::ST_DEV_SCL;
      esum_pkg::ST_DEV_SCL: begin
        state_next = (fixed_r || mean_ok_r) ? esum_pkg::ST_DEV_GO : esum_pkg::ST_MEAN_GO;
      end
      esum_pkg::ST_DEV_GO:    state_next = esum_pkg::ST_DEV_WAIT;
      esum_pkg::ST_DEV_WAIT:  if (div_rsp.done) state_next = esum_pkg::ST_MEAN_GO;
      esum_pkg::ST_MEAN_GO:   state_next = esum_pkg::ST_MEAN_WAIT;
      esum_pkg::ST_MEAN_WAIT: if (div_rsp.done) state_next = esum_pkg::ST_WRITE;
      esum_pkg::ST_WRITE:     state_next = esum_pkg::ST_LOAD;
      esum_pkg::ST_LOAD:      if (out_free) state_next = esum_pkg::ST_IDLE;
      default:                state_next = esum_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ram_we      = 1'b0;
    ram_raddr   = ptr;
    div_req     = '0;
    case (state)
      esum_pkg::ST_SPD_GO: begin
        div_req.start = 1'b1;
        div_req.mag   = esum_pkg::DIV_MW'(spd_prod);
        div_req.den   = {3'b0, dt_r, 5'b0};
      end
      esum_pkg::ST_DEV_GO: begin
        div_req.start = 1'b1;
        div_req.mag   = esum_pkg::DIV_MW'(num_mag);
        div_req.den   = fixed_r ? esum_pkg::DIV_DW'(ref_abs) : sum_abs;
      end
      esum_pkg::ST_MEAN_GO: begin
        div_req.start = 1'b1;
        div_req.mag   = esum_pkg::DIV_MW'(sum_abs);
        div_req.den   = esum_pkg::DIV_DW'(n_r);
      end
      esum_pkg::ST_WRITE: ram_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esum_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      win  <= esum_pkg::WINDOW_RESET;
      thr  <= esum_pkg::THRESHOLD_RESET;
      refv <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        esum_pkg::REG_WINDOW:    win  <= cfg_data[8:0];
        esum_pkg::REG_THRESHOLD: thr  <= cfg_data[12:0];
        esum_pkg::REG_REFERENCE: refv <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // history control state
  always_ff @(posedge clk) begin
    if (rst) begin
      has_prev  <= 1'b0;
      prev_cont <= 1'b0;
      prev_time <= '0;
      prev_pos  <= '0;
      count     <= '0;
      wr_slot   <= '0;
    end else if (take) begin
      if (sample.cmd == esum_pkg::CMD_CLEAR) begin
        has_prev  <= 1'b0;
        prev_cont <= 1'b0;
        prev_time <= '0;
        prev_pos  <= '0;
        count     <= '0;
        wr_slot   <= '0;
      end else if (!has_prev || dt >= esum_pkg::MIN_DT) begin
        has_prev  <= 1'b1;
        prev_cont <= sample.is_continuous;
        prev_time <= sample.time_us;
        prev_pos  <= sample.position_counts;
        if (has_prev && 32'(count) < 32'(HISTORY_LIMIT)) begin
          count <= count + 1'b1;
        end
      end
    end else if (state == esum_pkg::ST_WRITE) begin
      wr_slot <= (32'(wr_slot) == RING_DEPTH - 1) ? '0 : wr_slot + 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      case (state)
        esum_pkg::ST_IDLE: begin
          zero_res <= (sample.cmd == esum_pkg::CMD_CLEAR) || !has_prev;
          delta_r  <= delta;
          dt_r     <= dt;
        end
        esum_pkg::ST_SPD_MUL: begin
          spd_neg  <= delta_r[33];
          spd_prod <= (delta_r[33] ? 34'(-delta_r) : 34'(delta_r)) * esum_pkg::SPEED_K;
          n_r      <= n;
        end
        esum_pkg::ST_SPD_WAIT: begin
          if (div_rsp.done) begin
            speed_r  <= spd_neg ? -$signed(31'(q_spd)) : $signed(31'(q_spd));
            sum_r    <= spd_neg ? -40'(q_spd) : 40'(q_spd);
            peak_old <= '0;
            k        <= 9'd1;
            ptr      <= slot_prev;
            pend     <= 1'b0;
          end
        end
        esum_pkg::ST_SCAN: begin
          // older entries of the window, newest one is still in speed_r
          if (k < n_r) begin
            ptr  <= ptr_dec;
            k    <= k + 1'b1;
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            sum_r <= sum_r + 40'(rd_speed);
            if (rd_dev_abs > peak_old) begin
              peak_old <= rd_dev_abs;
            end
          end
        end
        esum_pkg::ST_DEV_MUL: begin
          fixed_r   <= fixed_c;
          mean_ok_r <= mean_ok_c;
          p1        <= fixed_c ? (42'(speed_r) - 42'(refv)) : prod_n;
        end
        esum_pkg::ST_DEV_SUB: begin
          diff_neg <= diff[42];
          diff_mag <= diff[42] ? 43'(-diff) : 43'(diff);
          dev_r    <= '0;
          dev_abs  <= '0;
        end
        esum_pkg::ST_DEV_SCL: num_mag <= diff_mag * esum_pkg::DEV_SCALE;
        esum_pkg::ST_DEV_WAIT: begin
          if (div_rsp.done) begin
            dev_r   <= diff_neg ? -$signed(21'(q_dev)) : $signed(21'(q_dev));
            dev_abs <= 20'(q_dev);
          end
        end
        esum_pkg::ST_MEAN_WAIT: begin
          if (div_rsp.done) begin
            mean_r <= sum_r[39] ? -$signed(31'(q_mean)) : $signed(31'(q_mean));
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else begin
      if (state == esum_pkg::ST_LOAD && out_free) begin
        result.valid          <= 1'b1;
        result.stored_samples <= esum_pkg::COUNT_W'(count);
        if (zero_res) begin
          result.speed_mrpm       <= '0;
          result.mean_mrpm        <= '0;
          result.sample_deviation <= '0;
          result.peak_deviation   <= '0;
          result.verdict          <= esum_pkg::VERDICT_FEW;
        end else begin
          result.speed_mrpm       <= speed_r;
          result.mean_mrpm        <= mean_r;
          result.sample_deviation <= dev_r;
          result.peak_deviation   <= peak_fin;
          if (32'(count) < 32'(esum_pkg::FEW_SAMPLES)) begin
            result.verdict <= esum_pkg::VERDICT_FEW;
          end else if (!mean_ok_r) begin
            result.verdict <= esum_pkg::VERDICT_SLOW;
          end else if (peak_fin <= 20'(thr)) begin
            result.verdict <= esum_pkg::VERDICT_UNIFORM;
          end else begin
            result.verdict <= esum_pkg::VERDICT_UNEVEN;
          end
        end
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy) else $error("divider started while busy");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == esum_pkg::ST_SCAN) |-> (k <= n_r)) else $error("scan ran past window");
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(HISTORY_LIMIT)) else $error("sample count above limit");
  a_load_only: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == esum_pkg::ST_LOAD)
    else $error("result raised outside load");
endmodule
